// ===== hw/rtl/depth_raster_radius_subsample_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the depth raster radius subsampler.
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DEPTH_RASTER_RADIUS_SUBSAMPLE_TOP_DEFINES_SVH
`define DEPTH_RASTER_RADIUS_SUBSAMPLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset.
`define DRRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define DRRS_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DRRS_ASSERT(lbl, clk, rst, prop, msg)
`define DRRS_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== hw/rtl/drrs_pkg.sv =====
// ---------------------------------------------------------------------------
// drrs_pkg
// Shared types and constants of the depth raster radius subsampler.
// ---------------------------------------------------------------------------
`default_nettype none

package drrs_pkg;

  // Default maximum sizes of the depth map.
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 4096;

  // Field widths.
  localparam int COORD_W    = 24;
  localparam int RADIUS_W   = 24;
  localparam int COLUMNS_W  = 11;
  localparam int ROWS_W     = 13;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MARK = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [COLUMNS_W-1:0] COLUMNS_RST = 11'd640;
  localparam logic [ROWS_W-1:0]    ROWS_RST    = 13'd480;

  // Causal neighbor slots.
  localparam int NB_COUNT = 4;
  localparam int NB_LEFT  = 0;
  localparam int NB_UL    = 1;
  localparam int NB_UP    = 2;
  localparam int NB_UR    = 3;

  // Queue between front and back; depth is a power of two.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } xyz_t;

  // One classified pixel on its way to the decision stage.
  typedef struct packed {
    xyz_t                p;
    logic                cand;
    logic                first_col;
    logic                first_row;
    logic                last_col;
    logic                frame_end;
    logic [NB_COUNT-1:0] close;
  } work_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] level;
    logic               full;
    logic               empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/drrs_if.sv =====
// ---------------------------------------------------------------------------
// drrs_if
// Valid/ready channels of the subsampler: pixels in, points out, and the
// configuration write channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface drrs_pix_if import drrs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;
  logic                      pixel_valid;
  logic                      mark;

  modport source (output valid, px, py, pz, pixel_valid, mark, input ready);
  modport sink   (input valid, px, py, pz, pixel_valid, mark, output ready);
endinterface

interface drrs_pt_if import drrs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic signed [COORD_W-1:0] qz;
  logic                      frame_end;

  modport source (output valid, qx, qy, qz, frame_end, input ready);
  modport sink   (input valid, qx, qy, qz, frame_end, output ready);
endinterface

interface drrs_cfg_if import drrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/depth_raster_radius_subsample_top.sv =====
// ---------------------------------------------------------------------------
// depth_raster_radius_subsample_top
// Radius subsampling of an organized depth map streamed in raster order.
// The block takes one pixel per clock while the point output keeps up, and
// emits a point for each pixel that is valid, marked (when marks are in use)
// and not within the radius of a kept left, upper-left, upper or upper-right
// neighbor. The line buffer is read at the acceptance edge; from acceptance
// to the point register a pixel then passes through a stage of squares, a
// stage of sums and compares, the queue, the decision stage and the point
// register. The decision stage's registered feedback of the left neighbor's
// kept bit sets the rate of one pixel per clock. The line buffer is a RAM of
// MAX_COLUMNS entries with no clearing pass after reset; an entry that was
// never written is used only when the column count grows in the middle of a
// frame. Configuration writes are taken in every cycle and belong to idle
// periods.
// ---------------------------------------------------------------------------
`default_nettype none

module depth_raster_radius_subsample_top import drrs_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  drrs_pix_if.sink  pixels,
  drrs_pt_if.source points,
  drrs_cfg_if.sink  cfg
);

  localparam int COL_W = $clog2(MAX_COLUMNS);

  logic             push, pop;
  work_t            push_work, head_work;
  logic [COL_W-1:0] push_addr, head_addr;
  fifo_stat_t       fifo_stat;

  // Acceptance, position tracking and distance measurement.
  drrs_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg       (cfg),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_work (push_work),
    .push_addr (push_addr)
  );

  // Queue between the two halves.
  drrs_fifo #(
    .ADDR_W (COL_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_work (push_work),
    .push_addr (push_addr),
    .pop       (pop),
    .head_work (head_work),
    .head_addr (head_addr),
    .stat      (fifo_stat)
  );

  // Keep decision and point output.
  drrs_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_work (head_work),
    .head_addr (head_addr),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .points    (points)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/drrs_ram.sv =====
// ---------------------------------------------------------------------------
// drrs_ram
// Generic RAM with one write port and two registered read ports.
// A read at the written address returns the old contents.
// ---------------------------------------------------------------------------
`default_nettype none

module drrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage array and read registers.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/drrs_front.sv =====
// ---------------------------------------------------------------------------
// drrs_front
// Accepts pixels, tracks the raster position, keeps the coordinate line
// buffer and measures the squared distance to all four causal neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module drrs_front import drrs_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  drrs_pix_if.sink                            pixels,
  drrs_cfg_if.sink                            cfg,
  input  wire fifo_stat_t                     fifo_stat,
  output logic                                push,
  output work_t                               push_work,
  output logic [$clog2(MAX_COLUMNS)-1:0]      push_addr
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CE_W  = (COL_W + 1 > COLUMNS_W) ? COL_W + 1 : COLUMNS_W;
  localparam int RE_W  = (ROW_W + 1 > ROWS_W) ? ROW_W + 1 : ROWS_W;
  localparam int SQ_W  = 2 * COORD_W;
  localparam int SUM_W = SQ_W + 2;

  // Squared difference of two coordinates; always below 2**48.
  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                               input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0]     d;
    logic signed [2*COORD_W+1:0] p;
    d = (COORD_W + 1)'(a) - (COORD_W + 1)'(b);
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  // Configuration registers.
  logic [R2_W-1:0]      r2;
  logic [COLUMNS_W-1:0] columns;
  logic [ROWS_W-1:0]    rows;
  logic                 use_mark;

  // Raster position.
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  // Pipeline stages.
  logic                  s1_valid, s2_valid, s3_valid;
  work_t                 s1_work, s2_work, s3_work;
  logic [COL_W-1:0]      s1_addr, s2_addr, s3_addr;
  logic [SQ_W-1:0]       s2_sq [NB_COUNT][3];
  xyz_t                  prev_cur;
  xyz_t                  prev_upper;

  logic                  accept;
  logic [FIFO_CW-1:0]    occupancy;
  logic [CE_W-1:0]       cols_x, cols_eff, cols_m1, col_x;
  logic [RE_W-1:0]       rows_x, rows_eff, rows_m1, row_x;
  logic [COL_W-1:0]      c, c_last, c_ur;
  logic [ROW_W-1:0]      r, r_last;
  logic                  last_col, last_row;
  xyz_t                  cur;
  logic [3*COORD_W-1:0]  ram_rd0, ram_rd1;
  xyz_t                  ram_up, ram_ur;
  xyz_t                  nb [NB_COUNT];
  logic [SUM_W-1:0]      d2_sum [NB_COUNT];
  work_t                 s2_done;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  // Credit check: every pixel in flight has a queue slot waiting for it.
  assign occupancy = fifo_stat.level + FIFO_CW'(s1_valid) + FIFO_CW'(s2_valid)
                   + FIFO_CW'(s3_valid);
  assign pixels.ready = (occupancy < FIFO_CW'(FIFO_DEPTH));
  assign accept = pixels.valid && pixels.ready;

  // Effective map size and clamped raster position.
  always_comb begin
    cols_x   = CE_W'(columns);
    cols_eff = (cols_x == '0) ? CE_W'(1) :
               (cols_x > CE_W'(MAX_COLUMNS)) ? CE_W'(MAX_COLUMNS) : cols_x;
    cols_m1  = cols_eff - CE_W'(1);
    c_last   = cols_m1[COL_W-1:0];
    col_x    = CE_W'(column_count);
    c        = (col_x >= cols_eff) ? c_last : column_count;
    last_col = (c == c_last);
    c_ur     = c + COL_W'(1);

    rows_x   = RE_W'(rows);
    rows_eff = (rows_x == '0) ? RE_W'(1) :
               (rows_x > RE_W'(MAX_ROWS)) ? RE_W'(MAX_ROWS) : rows_x;
    rows_m1  = rows_eff - RE_W'(1);
    r_last   = rows_m1[ROW_W-1:0];
    row_x    = RE_W'(row_count);
    r        = (row_x >= rows_eff) ? r_last : row_count;
    last_row = (r == r_last);
  end

  assign cur.x = pixels.px;
  assign cur.y = pixels.py;
  assign cur.z = pixels.pz;

  // Coordinate line buffer: read and write happen together at acceptance.
  drrs_ram #(
    .WIDTH ($bits(xyz_t)),
    .DEPTH (MAX_COLUMNS)
  ) u_coord_ram (
    .clk    (clk),
    .we     (accept),
    .waddr  (c),
    .wdata  (cur),
    .re     (accept),
    .raddr0 (c),
    .raddr1 (c_ur),
    .rdata0 (ram_rd0),
    .rdata1 (ram_rd1)
  );

  assign ram_up = ram_rd0;
  assign ram_ur = ram_rd1;

  // Neighbor coordinates of the pixel in the first stage.
  assign nb[NB_LEFT] = prev_cur;
  assign nb[NB_UL]   = prev_upper;
  assign nb[NB_UP]   = ram_up;
  assign nb[NB_UR]   = ram_ur;

  // Sum of the three squared differences per neighbor and the radius compare.
  always_comb begin
    s2_done = s2_work;
    for (int n = 0; n < NB_COUNT; n++) begin
      d2_sum[n] = SUM_W'(s2_sq[n][0]) + SUM_W'(s2_sq[n][1]) + SUM_W'(s2_sq[n][2]);
      s2_done.close[n] = (d2_sum[n] < SUM_W'(r2));
    end
  end

  // Control state: configuration, position and stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      r2           <= '0;
      columns      <= COLUMNS_RST;
      rows         <= ROWS_RST;
      use_mark     <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RADIUS: begin
            r2 <= {{RADIUS_W{1'b0}}, cfg.data[RADIUS_W-1:0]}
                * {{RADIUS_W{1'b0}}, cfg.data[RADIUS_W-1:0]};
          end
          REG_COLUMNS:  columns  <= cfg.data[COLUMNS_W-1:0];
          REG_ROWS:     rows     <= cfg.data[ROWS_W-1:0];
          REG_USE_MARK: use_mark <= cfg.data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : r + ROW_W'(1);
        end else begin
          column_count <= c + COL_W'(1);
          row_count    <= r;
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_work.p         <= cur;
      s1_work.cand      <= pixels.pixel_valid && (!use_mark || pixels.mark);
      s1_work.first_col <= (c == '0);
      s1_work.first_row <= (r == '0);
      s1_work.last_col  <= last_col;
      s1_work.frame_end <= last_col && last_row;
      s1_work.close     <= '0;
      s1_addr           <= c;
    end
    if (s1_valid) begin
      prev_cur   <= s1_work.p;
      prev_upper <= ram_up;
      s2_work    <= s1_work;
      s2_addr    <= s1_addr;
      for (int n = 0; n < NB_COUNT; n++) begin
        s2_sq[n][0] <= sq_diff(s1_work.p.x, nb[n].x);
        s2_sq[n][1] <= sq_diff(s1_work.p.y, nb[n].y);
        s2_sq[n][2] <= sq_diff(s1_work.p.z, nb[n].z);
      end
    end
    if (s2_valid) begin
      s3_work <= s2_done;
      s3_addr <= s2_addr;
    end
  end

  assign push      = s3_valid;
  assign push_work = s3_work;
  assign push_addr = s3_addr;

endmodule

`default_nettype wire

// ===== hw/rtl/drrs_fifo.sv =====
// ---------------------------------------------------------------------------
// drrs_fifo
// Short queue of classified pixels between the front and the decision stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "depth_raster_radius_subsample_top_defines.svh"

module drrs_fifo import drrs_pkg::*; #(
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire work_t             push_work,
  input  wire logic [ADDR_W-1:0] push_addr,
  input  wire logic              pop,
  output work_t                  head_work,
  output logic      [ADDR_W-1:0] head_addr,
  output fifo_stat_t             stat
);

  work_t              work_q [FIFO_DEPTH];
  logic [ADDR_W-1:0]  addr_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] level;

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        level <= level + FIFO_CW'(1);
      end else if (pop && !push) begin
        level <= level - FIFO_CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      work_q[wr_ptr] <= push_work;
      addr_q[wr_ptr] <= push_addr;
    end
  end

  assign head_work  = work_q[rd_ptr];
  assign head_addr  = addr_q[rd_ptr];
  assign stat.level = level;
  assign stat.full  = (level == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (level == '0);

  `DRRS_NEVER(a_no_overflow, clk, rst, push && stat.full, "push into a full queue")
  `DRRS_NEVER(a_no_underflow, clk, rst, pop && stat.empty, "pop from an empty queue")
  `DRRS_ASSERT(a_level_up, clk, rst, push && !pop |=> level == $past(level) + 1'b1, "queue level lost a push")

endmodule

`default_nettype wire

// ===== hw/rtl/drrs_back.sv =====
// ---------------------------------------------------------------------------
// drrs_back
// Decision stage: combines the distance flags with the kept bits of the
// neighbors, updates the kept-bit line buffer and drives the point output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "depth_raster_radius_subsample_top_defines.svh"

module drrs_back import drrs_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire work_t                            head_work,
  input  wire logic [$clog2(MAX_COLUMNS)-1:0]   head_addr,
  input  wire fifo_stat_t                       fifo_stat,
  output logic                                  pop,
  drrs_pt_if.source                             points
);

  localparam int COL_W = $clog2(MAX_COLUMNS);

  // Decision stage register.
  logic             b2_valid;
  work_t            b2_work;
  logic [COL_W-1:0] b2_addr;

  // Kept bits of the neighbors.
  logic [0:0]       rd_up, rd_ur;
  logic             byp_up, byp_ur, byp_val;
  logic             left_kept, ul_kept;
  logic             up_kept, ur_kept;

  // Output register.
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic                      out_frame_end;

  logic             retire, keep;
  logic [COL_W-1:0] head_addr_ur;

  assign head_addr_ur = head_addr + COL_W'(1);
  assign retire = b2_valid && (!out_valid || points.ready);
  assign pop    = !fifo_stat.empty && (!b2_valid || retire);

  // Kept-bit line buffer, written as each pixel is decided.
  drrs_ram #(
    .WIDTH (1),
    .DEPTH (MAX_COLUMNS)
  ) u_kept_ram (
    .clk    (clk),
    .we     (retire),
    .waddr  (b2_addr),
    .wdata  (keep),
    .re     (pop),
    .raddr0 (head_addr),
    .raddr1 (head_addr_ur),
    .rdata0 (rd_up),
    .rdata1 (rd_ur)
  );

  // A decision written in the same cycle as the read is forwarded.
  assign up_kept = byp_up ? byp_val : rd_up[0];
  assign ur_kept = byp_ur ? byp_val : rd_ur[0];

  // Suppression by any kept neighbor closer than the radius.
  always_comb begin
    keep = b2_work.cand && !(
      (!b2_work.first_col && left_kept && b2_work.close[NB_LEFT]) ||
      (!b2_work.first_col && !b2_work.first_row && ul_kept && b2_work.close[NB_UL]) ||
      (!b2_work.first_row && up_kept && b2_work.close[NB_UP]) ||
      (!b2_work.first_row && !b2_work.last_col && ur_kept && b2_work.close[NB_UR]));
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
      left_kept <= 1'b0;
      ul_kept   <= 1'b0;
      byp_up    <= 1'b0;
      byp_ur    <= 1'b0;
      byp_val   <= 1'b0;
    end else begin
      if (pop) begin
        b2_valid <= 1'b1;
        byp_up   <= retire && (b2_addr == head_addr);
        byp_ur   <= retire && (b2_addr == head_addr_ur);
        byp_val  <= keep;
      end else if (retire) begin
        b2_valid <= 1'b0;
      end
      if (retire) begin
        left_kept <= keep;
        ul_kept   <= up_kept;
      end
      if (retire && keep) begin
        out_valid <= 1'b1;
      end else if (points.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      b2_work <= head_work;
      b2_addr <= head_addr;
    end
    if (retire && keep) begin
      out_x         <= b2_work.p.x;
      out_y         <= b2_work.p.y;
      out_z         <= b2_work.p.z;
      out_frame_end <= b2_work.frame_end;
    end
  end

  assign points.valid     = out_valid;
  assign points.qx        = out_x;
  assign points.qy        = out_y;
  assign points.qz        = out_z;
  assign points.frame_end = out_frame_end;

  `DRRS_ASSERT(a_kept_shown, clk, rst, retire && keep |=> out_valid, "kept pixel did not reach the output")

endmodule

`default_nettype wire
